@@ rtl/bracketed_root_search_sequencer_defines.svh @@
// Assertion macros shared by the checker of the bracketed root search sequencer.
// No dependencies; included by the checker file.
`ifndef BRACKETED_ROOT_SEARCH_SEQUENCER_DEFINES_SVH
`define BRACKETED_ROOT_SEARCH_SEQUENCER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define BRSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brss assertion failed");

// Antecedent implies consequent in the next cycle.
`define BRSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brss assertion failed");

`endif

@@ rtl/brss_pkg.sv @@
// Package for the bracketed root search sequencer: widths, codes and state types.
// No dependencies; used by the sequencer, the false position unit and the checker.
`timescale 1ns / 1ps

package brss_pkg;

    localparam int VW       = 48;
    localparam int PW       = 2 * VW;
    localparam int CW       = VW - 1;
    localparam int IW       = 11;
    localparam int DIV_LAST = PW - 1;
    localparam int MUL_LAST = 5;

    localparam logic OP_START = 1'b0;
    localparam logic OP_VALUE = 1'b1;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    localparam logic [1:0] STATUS_CONVERGED = 2'd0;
    localparam logic [1:0] STATUS_NO_CONV   = 2'd1;
    localparam logic [1:0] STATUS_SAME_SIGN = 2'd2;

    localparam logic [2:0] CFG_TOLERANCE    = 3'd0;
    localparam logic [2:0] CFG_TINY         = 3'd1;
    localparam logic [2:0] CFG_MAX_ITER     = 3'd2;
    localparam logic [2:0] CFG_SOLVER_MODE  = 3'd3;
    localparam logic [2:0] CFG_SWITCH_COUNT = 3'd4;

    localparam logic [2:0] MODE_FALSI        = 3'd0;
    localparam logic [2:0] MODE_BISECT       = 3'd1;
    localparam logic [2:0] MODE_FALSI_BISECT = 3'd2;
    localparam logic [2:0] MODE_BISECT_FALSI = 3'd3;
    localparam logic [2:0] MODE_ALTERNATE    = 3'd4;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_WAIT_A,
        SQ_WAIT_B,
        SQ_WAIT_P,
        SQ_ADVANCE,
        SQ_CALC
    } t_seq_state;

    typedef enum logic [2:0] {
        FU_IDLE,
        FU_MUL,
        FU_COMB,
        FU_DIV,
        FU_DONE
    } t_fu_state;

    function automatic logic [VW-1:0] f_mag(input logic signed [VW-1:0] v);
        f_mag = v[VW-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

@@ rtl/bracketed_root_search_sequencer.sv @@
// Top level of the bracketed root search sequencer: search sequencer, bracket
// registers, configuration and output register. Uses brss_pkg and brss_falsi_unit.
//
//   channel   direction  handshake                     payload
//   input     in         i_in_valid / o_in_stall       i_op, i_bound_a, i_bound_b, i_f_value
//   output    out        o_out_valid / i_out_stall     o_kind, o_x_value, o_status,
//                                                      o_iterations, o_final_lo, o_final_hi
//   config    in         i_cfg_we                      i_cfg_index, i_cfg_data
//
// A start, a first bound value or a same-sign rejection writes its result straight into
// the output register. The second bound value and each probe value go through the advance
// state for a bisection step or a bracket collapse, and also through the shared unit for
// a false position step: six multiply slices, one combine, 96 divide steps.
// The input is stalled while a result waits in the output register or a probe is
// being computed. Reset (synchronous, active low) returns to idle with the
// configuration at its defaults.
`timescale 1ns / 1ps

module bracketed_root_search_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_op,
    input  logic signed [brss_pkg::VW-1:0] i_bound_a,
    input  logic signed [brss_pkg::VW-1:0] i_bound_b,
    input  logic signed [brss_pkg::VW-1:0] i_f_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_kind,
    output logic signed [brss_pkg::VW-1:0] o_x_value,
    output logic        [1:0]              o_status,
    output logic        [brss_pkg::IW-1:0] o_iterations,
    output logic signed [brss_pkg::VW-1:0] o_final_lo,
    output logic signed [brss_pkg::VW-1:0] o_final_hi,
    input  logic                           i_cfg_we,
    input  logic        [2:0]              i_cfg_index,
    input  logic        [brss_pkg::CW-1:0] i_cfg_data
);

    // Configuration registers.
    logic [brss_pkg::CW-1:0] r_tol, r_tiny;
    logic [9:0]              r_max_iter, r_switch;
    logic [2:0]              r_mode;

    // Search state.
    brss_pkg::t_seq_state           r_state, n_state;
    logic signed [brss_pkg::VW-1:0] r_x_first, n_x_first, r_x_second, n_x_second;
    logic signed [brss_pkg::VW-1:0] r_y_first, n_y_first, r_y_second, n_y_second;
    logic signed [brss_pkg::VW-1:0] r_x_probe, n_x_probe;
    logic [brss_pkg::IW-1:0]        r_iter, n_iter, r_alt, n_alt;

    // Output register.
    logic                           r_out_valid, n_out_valid;
    logic                           r_kind, n_kind;
    logic signed [brss_pkg::VW-1:0] r_x_value, n_x_value, r_lo, n_lo, r_hi, n_hi;
    logic [1:0]                     r_status, n_status;
    logic [brss_pkg::IW-1:0]        r_iters, n_iters;

    logic                           in_acc, fu_start, fu_done, bis, conv, stop;
    logic signed [brss_pkg::VW-1:0] fu_q;
    logic [brss_pkg::IW-1:0]        iter_inc;
    logic signed [brss_pkg::VW:0]   xsum, xdiff;
    logic [brss_pkg::VW-1:0]        width_mag;

    brss_falsi_unit u_falsi (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (fu_start),
        .i_x_first  (r_x_first),
        .i_x_second (r_x_second),
        .i_y_first  (r_y_first),
        .i_y_second (r_y_second),
        .i_tiny     (r_tiny),
        .o_done     (fu_done),
        .o_quotient (fu_q)
    );

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_x_value    = r_x_value;
    assign o_status     = r_status;
    assign o_iterations = r_iters;
    assign o_final_lo   = r_lo;
    assign o_final_hi   = r_hi;

    // Inputs are taken only in the waiting states, with the output register empty.
    assign o_in_stall = r_out_valid ||
                        !(r_state == brss_pkg::SQ_IDLE || r_state == brss_pkg::SQ_WAIT_A ||
                          r_state == brss_pkg::SQ_WAIT_B || r_state == brss_pkg::SQ_WAIT_P);
    assign in_acc = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_x_first   = r_x_first;
        n_x_second  = r_x_second;
        n_y_first   = r_y_first;
        n_y_second  = r_y_second;
        n_x_probe   = r_x_probe;
        n_iter      = r_iter;
        n_alt       = r_alt;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_x_value   = r_x_value;
        n_status    = r_status;
        n_iters     = r_iters;
        n_lo        = r_lo;
        n_hi        = r_hi;
        fu_start    = 1'b0;
        bis         = 1'b0;

        iter_inc  = r_iter + 1'b1;
        conv      = brss_pkg::f_mag(i_f_value) < {1'b0, r_tol};
        stop      = iter_inc > {1'b0, r_max_iter};
        xsum      = {r_x_first[brss_pkg::VW-1], r_x_first} +
                    {r_x_second[brss_pkg::VW-1], r_x_second};
        xdiff     = {r_x_second[brss_pkg::VW-1], r_x_second} -
                    {r_x_first[brss_pkg::VW-1], r_x_first};
        width_mag = xdiff[brss_pkg::VW] ? brss_pkg::VW'(-xdiff) : xdiff[brss_pkg::VW-1:0];

        unique case (r_state)
            brss_pkg::SQ_IDLE, brss_pkg::SQ_WAIT_A, brss_pkg::SQ_WAIT_B,
            brss_pkg::SQ_WAIT_P: begin
                if (in_acc) begin
                    if (i_op == brss_pkg::OP_START) begin
                        // A start transaction restarts the search from any phase.
                        n_x_first   = i_bound_a;
                        n_x_second  = i_bound_b;
                        n_y_first   = '0;
                        n_y_second  = '0;
                        n_x_probe   = i_bound_a;
                        n_iter      = '0;
                        n_alt       = '0;
                        n_out_valid = 1'b1;
                        n_kind      = brss_pkg::KIND_REQUEST;
                        n_x_value   = i_bound_a;
                        n_status    = brss_pkg::STATUS_CONVERGED;
                        n_iters     = '0;
                        n_lo        = '0;
                        n_hi        = '0;
                        n_state     = brss_pkg::SQ_WAIT_A;
                    end else if (r_state == brss_pkg::SQ_WAIT_A) begin
                        n_y_first   = i_f_value;
                        n_out_valid = 1'b1;
                        n_kind      = brss_pkg::KIND_REQUEST;
                        n_x_value   = r_x_second;
                        n_status    = brss_pkg::STATUS_CONVERGED;
                        n_iters     = '0;
                        n_lo        = '0;
                        n_hi        = '0;
                        n_state     = brss_pkg::SQ_WAIT_B;
                    end else if (r_state == brss_pkg::SQ_WAIT_B) begin
                        n_y_second = i_f_value;
                        // Both ends strictly positive or strictly negative: no bracket.
                        if ((!r_y_first[brss_pkg::VW-1] && r_y_first != '0 &&
                             !i_f_value[brss_pkg::VW-1] && i_f_value != '0) ||
                            (r_y_first[brss_pkg::VW-1] && i_f_value[brss_pkg::VW-1])) begin
                            n_out_valid = 1'b1;
                            n_kind      = brss_pkg::KIND_DONE;
                            n_x_value   = r_x_first;
                            n_status    = brss_pkg::STATUS_SAME_SIGN;
                            n_iters     = '0;
                            n_lo        = r_x_first;
                            n_hi        = r_x_second;
                            n_state     = brss_pkg::SQ_IDLE;
                        end else begin
                            n_state = brss_pkg::SQ_ADVANCE;
                        end
                    end else if (r_state == brss_pkg::SQ_WAIT_P) begin
                        n_iter = iter_inc;
                        n_alt  = r_alt + 1'b1;
                        if (conv || stop) begin
                            // The last probe does not re-bracket on a stop.
                            n_out_valid = 1'b1;
                            n_kind      = brss_pkg::KIND_DONE;
                            n_x_value   = r_x_probe;
                            n_status    = conv ? brss_pkg::STATUS_CONVERGED
                                               : brss_pkg::STATUS_NO_CONV;
                            n_iters     = iter_inc;
                            n_lo        = r_x_first;
                            n_hi        = r_x_second;
                            n_state     = brss_pkg::SQ_IDLE;
                        end else begin
                            if (r_y_first[brss_pkg::VW-1] == i_f_value[brss_pkg::VW-1]) begin
                                n_x_first = r_x_probe;
                                n_y_first = i_f_value;
                            end else begin
                                n_x_second = r_x_probe;
                                n_y_second = i_f_value;
                            end
                            n_state = brss_pkg::SQ_ADVANCE;
                        end
                    end
                    // A function value while idle is dropped without a result.
                end
            end
            brss_pkg::SQ_ADVANCE: begin
                if (width_mag < {1'b0, r_tiny}) begin
                    // Bracket collapsed below the minimum width.
                    n_out_valid = 1'b1;
                    n_kind      = brss_pkg::KIND_DONE;
                    n_x_value   = r_x_probe;
                    n_status    = brss_pkg::STATUS_NO_CONV;
                    n_iters     = r_iter;
                    n_lo        = r_x_first;
                    n_hi        = r_x_second;
                    n_state     = brss_pkg::SQ_IDLE;
                end else begin
                    unique case (r_mode)
                        brss_pkg::MODE_BISECT:       bis = 1'b1;
                        brss_pkg::MODE_FALSI_BISECT: bis = r_iter > {1'b0, r_switch};
                        brss_pkg::MODE_BISECT_FALSI: bis = r_iter <= {1'b0, r_switch};
                        brss_pkg::MODE_ALTERNATE: begin
                            bis = r_alt > {1'b0, r_switch};
                            if (bis && r_alt >= {r_switch, 1'b0}) begin
                                n_alt = '0;
                            end
                        end
                        default: bis = 1'b0;
                    endcase
                    if (bis) begin
                        n_x_probe   = xsum[brss_pkg::VW:1];
                        n_out_valid = 1'b1;
                        n_kind      = brss_pkg::KIND_REQUEST;
                        n_x_value   = xsum[brss_pkg::VW:1];
                        n_status    = brss_pkg::STATUS_CONVERGED;
                        n_iters     = '0;
                        n_lo        = '0;
                        n_hi        = '0;
                        n_state     = brss_pkg::SQ_WAIT_P;
                    end else begin
                        fu_start = 1'b1;
                        n_state  = brss_pkg::SQ_CALC;
                    end
                end
            end
            brss_pkg::SQ_CALC: begin
                if (fu_done) begin
                    n_x_probe   = fu_q;
                    n_out_valid = 1'b1;
                    n_kind      = brss_pkg::KIND_REQUEST;
                    n_x_value   = fu_q;
                    n_status    = brss_pkg::STATUS_CONVERGED;
                    n_iters     = '0;
                    n_lo        = '0;
                    n_hi        = '0;
                    n_state     = brss_pkg::SQ_WAIT_P;
                end
            end
            default: n_state = brss_pkg::SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brss_pkg::SQ_IDLE;
            r_out_valid <= 1'b0;
            r_x_first   <= '0;
            r_x_second  <= '0;
            r_y_first   <= '0;
            r_y_second  <= '0;
            r_x_probe   <= '0;
            r_iter      <= '0;
            r_alt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_x_first   <= n_x_first;
            r_x_second  <= n_x_second;
            r_y_first   <= n_y_first;
            r_y_second  <= n_y_second;
            r_x_probe   <= n_x_probe;
            r_iter      <= n_iter;
            r_alt       <= n_alt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_x_value <= n_x_value;
        r_status  <= n_status;
        r_iters   <= n_iters;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
    end

    // Configuration writes; unused indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol      <= brss_pkg::CW'(1);
            r_tiny     <= brss_pkg::CW'(1);
            r_max_iter <= 10'd100;
            r_mode     <= brss_pkg::MODE_FALSI;
            r_switch   <= 10'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                brss_pkg::CFG_TOLERANCE:    r_tol      <= i_cfg_data;
                brss_pkg::CFG_TINY:         r_tiny     <= i_cfg_data;
                brss_pkg::CFG_MAX_ITER:     r_max_iter <= i_cfg_data[9:0];
                brss_pkg::CFG_SOLVER_MODE:  r_mode     <= i_cfg_data[2:0];
                brss_pkg::CFG_SWITCH_COUNT: r_switch   <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/brss_falsi_unit.sv @@
// Shared false position unit: sliced multiplier for the two cross products,
// then a one bit per cycle restoring divider with saturation. Uses brss_pkg.
`timescale 1ns / 1ps

module brss_falsi_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [brss_pkg::VW-1:0] i_x_first,
    input  logic signed [brss_pkg::VW-1:0] i_x_second,
    input  logic signed [brss_pkg::VW-1:0] i_y_first,
    input  logic signed [brss_pkg::VW-1:0] i_y_second,
    input  logic        [brss_pkg::CW-1:0] i_tiny,
    output logic                           o_done,
    output logic signed [brss_pkg::VW-1:0] o_quotient
);

    brss_pkg::t_fu_state r_state, n_state;
    logic [6:0]              r_cnt, n_cnt;
    logic [brss_pkg::VW-1:0] r_a1, n_a1, r_b1, n_b1, r_a2, n_a2, r_b2, n_b2;
    logic                    r_s1, n_s1, r_s2, n_s2, r_dneg, n_dneg, r_neg, n_neg;
    logic [brss_pkg::VW-1:0] r_d, n_d;
    logic [brss_pkg::PW-1:0] r_m1, n_m1, r_m2, n_m2, r_num, n_num;
    logic [brss_pkg::VW-1:0] r_rem, n_rem, r_quo, n_quo;
    logic                    r_sticky, n_sticky;

    logic signed [brss_pkg::VW:0] dy;
    logic [brss_pkg::VW-1:0]      dmag, dsel, mul_a, mul_b, qsat;
    logic                         dneg_sel, sel2;
    logic [1:0]                   k;
    logic [15:0]                  slice;
    logic [63:0]                  prod;
    logic [brss_pkg::PW-1:0]      addend, nsum;
    logic                         nsgn;
    logic [brss_pkg::VW:0]        rem2;
    logic                         ge;
    logic [brss_pkg::VW-1:0]      neg_lim, pos_lim;

    always_comb begin
        neg_lim = {1'b1, {(brss_pkg::VW-1){1'b0}}};
        pos_lim = {1'b0, {(brss_pkg::VW-1){1'b1}}};

        // Denominator with its floor.
        dy       = {i_y_first[brss_pkg::VW-1], i_y_first} - {i_y_second[brss_pkg::VW-1], i_y_second};
        dneg_sel = dy[brss_pkg::VW];
        dmag     = dneg_sel ? brss_pkg::VW'(-dy) : dy[brss_pkg::VW-1:0];
        dsel     = dmag;
        if (dmag < {1'b0, i_tiny}) begin
            dsel     = {1'b0, i_tiny};
            dneg_sel = 1'b0;
        end
        if (dsel == '0) begin
            dsel = brss_pkg::VW'(1);
        end

        // One 48 by 16 slice per cycle.
        sel2  = (r_cnt >= 7'd3);
        k     = sel2 ? 2'(r_cnt - 7'd3) : r_cnt[1:0];
        mul_a = sel2 ? r_a2 : r_a1;
        mul_b = sel2 ? r_b2 : r_b1;
        unique case (k)
            2'd0:    slice = mul_b[15:0];
            2'd1:    slice = mul_b[31:16];
            default: slice = mul_b[47:32];
        endcase
        prod = 64'(mul_a) * 64'(slice);
        unique case (k)
            2'd0:    addend = {32'b0, prod};
            2'd1:    addend = {16'b0, prod, 16'b0};
            default: addend = {prod, 32'b0};
        endcase

        // Combine the cross products into a magnitude and a sign.
        if (r_s1 == r_s2) begin
            nsum = r_m1 + r_m2;
            nsgn = r_s1;
        end else if (r_m1 >= r_m2) begin
            nsum = r_m1 - r_m2;
            nsgn = r_s1;
        end else begin
            nsum = r_m2 - r_m1;
            nsgn = r_s2;
        end

        rem2 = {r_rem, r_num[brss_pkg::PW-1]};
        ge   = (rem2 >= {1'b0, r_d});

        if (r_neg) begin
            qsat       = (r_sticky || r_quo > neg_lim) ? neg_lim : r_quo;
            o_quotient = signed'(~qsat + 1'b1);
        end else begin
            qsat       = (r_sticky || r_quo > pos_lim) ? pos_lim : r_quo;
            o_quotient = signed'(qsat);
        end

        n_state  = r_state;
        n_cnt    = r_cnt;
        n_a1     = r_a1;
        n_b1     = r_b1;
        n_a2     = r_a2;
        n_b2     = r_b2;
        n_s1     = r_s1;
        n_s2     = r_s2;
        n_dneg   = r_dneg;
        n_neg    = r_neg;
        n_d      = r_d;
        n_m1     = r_m1;
        n_m2     = r_m2;
        n_num    = r_num;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_sticky = r_sticky;
        o_done   = 1'b0;

        unique case (r_state)
            brss_pkg::FU_IDLE: begin
                if (i_start) begin
                    n_a1    = brss_pkg::f_mag(i_y_first);
                    n_b1    = brss_pkg::f_mag(i_x_second);
                    n_a2    = brss_pkg::f_mag(i_y_second);
                    n_b2    = brss_pkg::f_mag(i_x_first);
                    n_s1    = i_y_first[brss_pkg::VW-1] != i_x_second[brss_pkg::VW-1];
                    n_s2    = i_y_second[brss_pkg::VW-1] == i_x_first[brss_pkg::VW-1];
                    n_d     = dsel;
                    n_dneg  = dneg_sel;
                    n_m1    = '0;
                    n_m2    = '0;
                    n_cnt   = '0;
                    n_state = brss_pkg::FU_MUL;
                end
            end
            brss_pkg::FU_MUL: begin
                if (sel2) begin
                    n_m2 = r_m2 + addend;
                end else begin
                    n_m1 = r_m1 + addend;
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(brss_pkg::MUL_LAST)) begin
                    n_state = brss_pkg::FU_COMB;
                end
            end
            brss_pkg::FU_COMB: begin
                n_num    = nsum;
                n_neg    = nsgn != r_dneg;
                n_rem    = '0;
                n_quo    = '0;
                n_sticky = 1'b0;
                n_cnt    = '0;
                n_state  = brss_pkg::FU_DIV;
            end
            brss_pkg::FU_DIV: begin
                n_num    = {r_num[brss_pkg::PW-2:0], 1'b0};
                n_rem    = ge ? brss_pkg::VW'(rem2 - {1'b0, r_d}) : rem2[brss_pkg::VW-1:0];
                n_sticky = r_sticky | r_quo[brss_pkg::VW-1];
                n_quo    = {r_quo[brss_pkg::VW-2:0], ge};
                n_cnt    = r_cnt + 7'd1;
                if (r_cnt == 7'(brss_pkg::DIV_LAST)) begin
                    n_state = brss_pkg::FU_DONE;
                end
            end
            brss_pkg::FU_DONE: begin
                o_done  = 1'b1;
                n_state = brss_pkg::FU_IDLE;
            end
            default: n_state = brss_pkg::FU_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brss_pkg::FU_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1     <= n_a1;
        r_b1     <= n_b1;
        r_a2     <= n_a2;
        r_b2     <= n_b2;
        r_s1     <= n_s1;
        r_s2     <= n_s2;
        r_dneg   <= n_dneg;
        r_neg    <= n_neg;
        r_d      <= n_d;
        r_m1     <= n_m1;
        r_m2     <= n_m2;
        r_num    <= n_num;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_sticky <= n_sticky;
    end

endmodule

@@ rtl/brss_checker.sv @@
// Port-level checker for the bracketed root search sequencer, with its bind.
// Depends on brss_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "bracketed_root_search_sequencer_defines.svh"

module brss_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic                           o_kind,
    input logic        [1:0]              o_status,
    input logic        [brss_pkg::IW-1:0] o_iterations,
    input logic signed [brss_pkg::VW-1:0] o_final_lo,
    input logic signed [brss_pkg::VW-1:0] o_final_hi
);

    // A pending result holds while the consumer stalls.
    `BRSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // No new transaction is taken while a result waits.
    `BRSS_ASSERT_SAME(a_in_blocked, i_clk, i_rst_n, o_out_valid, o_in_stall)

    // Requests carry zero status, count and bounds.
    `BRSS_ASSERT_SAME(a_req_clean, i_clk, i_rst_n, o_out_valid && o_kind == brss_pkg::KIND_REQUEST,
        o_status == '0 && o_iterations == '0 && o_final_lo == '0 && o_final_hi == '0)

    // A finished search reports one of the three status codes.
    `BRSS_ASSERT_SAME(a_done_status, i_clk, i_rst_n, o_out_valid && o_kind == brss_pkg::KIND_DONE,
        o_status == brss_pkg::STATUS_CONVERGED || o_status == brss_pkg::STATUS_NO_CONV ||
        o_status == brss_pkg::STATUS_SAME_SIGN)

endmodule

bind bracketed_root_search_sequencer brss_checker u_brss_checker (.*);
